/* design/at_response_line_classifier_unit_assert.svh */
// Assertion macros for the line classifier top level.
`ifndef AT_RESPONSE_LINE_CLASSIFIER_UNIT_ASSERT_SVH
`define AT_RESPONSE_LINE_CLASSIFIER_UNIT_ASSERT_SVH

// The condition implies the expectation in the same cycle.
`define ALRC_ASSERT_SAME(label, cond, expect_expr) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |-> (expect_expr)) else $error("line classifier check failed");

// The condition implies the expectation in the next cycle.
`define ALRC_ASSERT_NEXT(label, cond, expect_expr) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |=> (expect_expr)) else $error("line classifier check failed");

`endif

/* design/alrc_pkg.sv */
// ---------------------------------------------------------------------------
// Line classifier package
// Shared types, codes, match strings and helper functions.
// ---------------------------------------------------------------------------
package alrc_pkg;

   localparam int LINE_MAX    = 1024;
   localparam int TOPIC_MAX   = 64;
   localparam int PAYLOAD_MAX = 256;
   localparam int ADDR_W      = $clog2(LINE_MAX);

   // Result kinds.
   localparam logic [3:0] KIND_READ  = 4'd0;
   localparam logic [3:0] KIND_CHUNK = 4'd1;
   localparam logic [3:0] KIND_PLAIN = 4'd2;
   localparam logic [3:0] KIND_OK    = 4'd3;
   localparam logic [3:0] KIND_ERROR = 4'd4;
   localparam logic [3:0] KIND_FAIL  = 4'd5;
   localparam logic [3:0] KIND_BUSY  = 4'd6;
   localparam logic [3:0] KIND_MQTT  = 4'd7;
   localparam logic [3:0] KIND_DISC  = 4'd8;

   // Request types.
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Characters.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Match strings, first character in the top byte.
   localparam logic [103:0] PAT_RECV = "+MQTTSUBRECV:";
   localparam logic [135:0] PAT_DISC = "+MQTTDISCONNECTED";
   localparam logic [15:0]  PAT_OK   = "OK";
   localparam logic [39:0]  PAT_ERR  = "ERROR";
   localparam logic [31:0]  PAT_FAIL = "FAIL";
   localparam logic [71:0]  PAT_BUSY = "busy p...";

   localparam logic [16:0] LEN_SAT = 17'd65535;

   typedef struct packed {
      logic                  req_type;
      logic [7:0]            rx_byte;
      logic [9:0]            read_index;
   } req_item_type;

   typedef struct packed {
      logic [3:0] line_kind;
      logic [9:0] line_len;
      logic [9:0] topic_start;
      logic [5:0] topic_size;
      logic [9:0] body_start;
      logic [7:0] payload_len;
      logic [7:0] read_data;
      logic       last;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CHUNK,
      ST_STEP,
      ST_LINE,
      ST_READ,
      ST_READ_OUT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      PH_SEEK,
      PH_QUOTE1,
      PH_QUOTE2,
      PH_COMMA1,
      PH_NUMBER,
      PH_PAYLOAD
   } mqtt_phase_type;

   typedef enum logic [1:0] {
      PARSE_SPACE,
      PARSE_DIGITS,
      PARSE_DONE
   } parse_state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic latch;
      logic chunk_load;
      logic restart;
      logic step;
      logic line_load;
      logic read_load;
   } alrc_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic is_read;
      logic need_chunk;
      logic is_newline;
      logic out_free;
   } alrc_status_type;

   function automatic logic is_crlf(input logic [7:0] c);
      return (c == CH_CR) || (c == CH_LF);
   endfunction

   // Byte idx of a string of nbytes characters held in the low bits.
   function automatic logic [7:0] pat_byte(input logic [135:0] pat, input int nbytes,
                                           input int idx);
      return pat[8*(nbytes-1-idx) +: 8];
   endfunction

endpackage

/* design/alrc_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module alrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/alrc_ctrl.sv */
// ---------------------------------------------------------------------------
// Line classifier controller
// Sequences one request at a time and issues datapath commands.
// ---------------------------------------------------------------------------
module alrc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  alrc_pkg::alrc_status_type status,
   output alrc_pkg::alrc_cmd_type    cmd,
   output alrc_pkg::ctrl_state_type  state
);

   alrc_pkg::ctrl_state_type state_ff;
   alrc_pkg::ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alrc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         alrc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = alrc_pkg::ST_DECODE;
            end
         end
         alrc_pkg::ST_DECODE: begin
            if (status.is_read) begin
               state_in = alrc_pkg::ST_READ;
            end else if (status.need_chunk) begin
               state_in = alrc_pkg::ST_CHUNK;
            end else begin
               state_in = alrc_pkg::ST_STEP;
            end
         end
         alrc_pkg::ST_CHUNK: begin
            if (status.out_free) begin
               cmd.chunk_load = 1'b1;
               cmd.restart    = 1'b1;
               state_in       = alrc_pkg::ST_STEP;
            end
         end
         alrc_pkg::ST_STEP: begin
            cmd.step = 1'b1;
            state_in = status.is_newline ? alrc_pkg::ST_LINE : alrc_pkg::ST_IDLE;
         end
         alrc_pkg::ST_LINE: begin
            if (status.out_free) begin
               cmd.line_load = 1'b1;
               cmd.restart   = 1'b1;
               state_in      = alrc_pkg::ST_IDLE;
            end
         end
         alrc_pkg::ST_READ: begin
            state_in = alrc_pkg::ST_READ_OUT;
         end
         alrc_pkg::ST_READ_OUT: begin
            if (status.out_free) begin
               cmd.read_load = 1'b1;
               state_in      = alrc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = alrc_pkg::ST_IDLE;
         end
      endcase
   end

   assign state = state_ff;

endmodule

/* design/alrc_datapath.sv */
// ---------------------------------------------------------------------------
// Line classifier datapath
// Line fill count, per-byte pattern trackers and the result register.
// ---------------------------------------------------------------------------
module alrc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  alrc_pkg::req_item_type              req_data,
   input  alrc_pkg::alrc_cmd_type              cmd,
   output alrc_pkg::alrc_status_type           status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output alrc_pkg::rsp_item_type              rsp_data,
   output logic                                wr_en,
   output logic [alrc_pkg::ADDR_W-1:0]         wr_addr,
   output logic [7:0]                          wr_data,
   output logic [alrc_pkg::ADDR_W-1:0]         rd_addr,
   input  logic [7:0]                          rd_data
);

   alrc_pkg::req_item_type req_ff, req_in;
   logic [9:0] fill_ff, fill_in;

   // MQTT message tracker.
   logic                      zseen_ff, zseen_in;
   alrc_pkg::mqtt_phase_type  phase_ff, phase_in;
   logic [3:0]                mcnt_ff, mcnt_in;
   logic [9:0]                t1_ff, t1_in, t2_ff, t2_in, c2_ff, c2_in, trim_ff, trim_in;
   alrc_pkg::parse_state_type parse_ff, parse_in;
   logic                      neg_ff, neg_in;
   logic [16:0]               mag_ff, mag_in;

   // Disconnect tracker.
   logic [4:0] dcnt_ff, dcnt_in;
   logic       disc_ff, disc_in;

   // Whole-line word trackers.
   logic       wstart_ff, wstart_in, wgap_ff, wgap_in;
   logic [1:0] okcnt_ff, okcnt_in;
   logic [2:0] errcnt_ff, errcnt_in, failcnt_ff, failcnt_in;
   logic       okbad_ff, okbad_in, errbad_ff, errbad_in, failbad_ff, failbad_in;

   // Line ending tracker.
   logic [71:0] bwin_ff, bwin_in;
   logic [3:0]  brun_ff, brun_in;
   logic        bbrk_ff, bbrk_in;

   // Result register.
   alrc_pkg::rsp_item_type out_ff, out_in;
   logic                   out_valid_ff, out_valid_in;

   logic [7:0]  c;
   logic [19:0] mag_next;
   logic        mqtt_hit, busy_hit;
   logic [9:0]  topic_raw;
   logic [3:0]  kind;

   assign c        = req_ff.rx_byte;
   assign mag_next = {mag_ff, 3'b000} + {2'b00, mag_ff, 1'b0} + {16'd0, c[3:0]};

   // Status toward the controller.
   assign status.is_read    = (req_ff.req_type == alrc_pkg::REQ_READ);
   assign status.need_chunk = (fill_ff >= 10'(alrc_pkg::LINE_MAX - 1));
   assign status.is_newline = (c == alrc_pkg::CH_LF);
   assign status.out_free   = !out_valid_ff || rsp_ready;

   // Store port.
   assign wr_en   = cmd.step;
   assign wr_addr = fill_ff;
   assign wr_data = c;
   assign rd_addr = req_ff.read_index;

   // Classification of the completed line.
   assign mqtt_hit  = (phase_ff == alrc_pkg::PH_PAYLOAD) && !(neg_ff && (mag_ff != '0)) &&
                      ({7'd0, trim_ff} >= mag_ff);
   assign busy_hit  = (brun_ff >= 4'd9) && (bwin_ff == alrc_pkg::PAT_BUSY);
   assign topic_raw = t2_ff - t1_ff - 10'd1;

   always_comb begin
      if (mqtt_hit) begin
         kind = alrc_pkg::KIND_MQTT;
      end else if (disc_ff) begin
         kind = alrc_pkg::KIND_DISC;
      end else if (!okbad_ff && okcnt_ff == 2'd2) begin
         kind = alrc_pkg::KIND_OK;
      end else if (!errbad_ff && errcnt_ff == 3'd5) begin
         kind = alrc_pkg::KIND_ERROR;
      end else if (!failbad_ff && failcnt_ff == 3'd4) begin
         kind = alrc_pkg::KIND_FAIL;
      end else if (busy_hit) begin
         kind = alrc_pkg::KIND_BUSY;
      end else begin
         kind = alrc_pkg::KIND_PLAIN;
      end
   end

   // Tracker and fill updates.
   always_comb begin
      req_in     = req_ff;
      fill_in    = fill_ff;
      zseen_in   = zseen_ff;
      phase_in   = phase_ff;
      mcnt_in    = mcnt_ff;
      t1_in      = t1_ff;
      t2_in      = t2_ff;
      c2_in      = c2_ff;
      trim_in    = trim_ff;
      parse_in   = parse_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      dcnt_in    = dcnt_ff;
      disc_in    = disc_ff;
      wstart_in  = wstart_ff;
      wgap_in    = wgap_ff;
      okcnt_in   = okcnt_ff;
      errcnt_in  = errcnt_ff;
      failcnt_in = failcnt_ff;
      okbad_in   = okbad_ff;
      errbad_in  = errbad_ff;
      failbad_in = failbad_ff;
      bwin_in    = bwin_ff;
      brun_in    = brun_ff;
      bbrk_in    = bbrk_ff;

      if (cmd.latch) begin
         req_in = req_data;
      end

      if (cmd.step) begin
         fill_in = fill_ff + 10'd1;

         // Prefix-limited matching stops at the first zero byte.
         if (c == alrc_pkg::CH_NUL) begin
            zseen_in = 1'b1;
         end else if (!zseen_ff) begin
            case (phase_ff)
               alrc_pkg::PH_SEEK: begin
                  if (c == alrc_pkg::pat_byte(alrc_pkg::PAT_RECV, 13, int'(mcnt_ff))) begin
                     if (mcnt_ff == 4'd12) begin
                        phase_in = alrc_pkg::PH_QUOTE1;
                     end else begin
                        mcnt_in = mcnt_ff + 4'd1;
                     end
                  end else begin
                     mcnt_in = (c == alrc_pkg::CH_PLUS) ? 4'd1 : 4'd0;
                  end
               end
               alrc_pkg::PH_QUOTE1: begin
                  if (c == alrc_pkg::CH_QUOTE) begin
                     t1_in    = fill_ff;
                     phase_in = alrc_pkg::PH_QUOTE2;
                  end
               end
               alrc_pkg::PH_QUOTE2: begin
                  if (c == alrc_pkg::CH_QUOTE) begin
                     t2_in    = fill_ff;
                     phase_in = alrc_pkg::PH_COMMA1;
                  end
               end
               alrc_pkg::PH_COMMA1: begin
                  if (c == alrc_pkg::CH_COMMA) begin
                     phase_in = alrc_pkg::PH_NUMBER;
                     parse_in = alrc_pkg::PARSE_SPACE;
                     neg_in   = 1'b0;
                     mag_in   = '0;
                  end
               end
               alrc_pkg::PH_NUMBER: begin
                  // Length field, parsed like atoi.
                  case (parse_ff)
                     alrc_pkg::PARSE_SPACE: begin
                        if (c == alrc_pkg::CH_SPACE ||
                            (c >= alrc_pkg::CH_TAB && c <= alrc_pkg::CH_CR)) begin
                           parse_in = alrc_pkg::PARSE_SPACE;
                        end else if (c == alrc_pkg::CH_PLUS || c == alrc_pkg::CH_MINUS) begin
                           neg_in   = (c == alrc_pkg::CH_MINUS);
                           parse_in = alrc_pkg::PARSE_DIGITS;
                        end else if (c >= alrc_pkg::CH_ZERO && c <= alrc_pkg::CH_NINE) begin
                           mag_in   = {13'd0, c[3:0]};
                           parse_in = alrc_pkg::PARSE_DIGITS;
                        end else begin
                           parse_in = alrc_pkg::PARSE_DONE;
                        end
                     end
                     alrc_pkg::PARSE_DIGITS: begin
                        if (c >= alrc_pkg::CH_ZERO && c <= alrc_pkg::CH_NINE) begin
                           mag_in = (mag_next > {3'd0, alrc_pkg::LEN_SAT}) ?
                                    alrc_pkg::LEN_SAT : mag_next[16:0];
                        end else begin
                           parse_in = alrc_pkg::PARSE_DONE;
                        end
                     end
                     default: begin
                        parse_in = alrc_pkg::PARSE_DONE;
                     end
                  endcase
                  if (c == alrc_pkg::CH_COMMA) begin
                     c2_in    = fill_ff;
                     trim_in  = '0;
                     phase_in = alrc_pkg::PH_PAYLOAD;
                  end
               end
               default: begin
                  // Payload bytes up to the last one that is not CR or LF.
                  if (!alrc_pkg::is_crlf(c)) begin
                     trim_in = fill_ff - c2_ff;
                  end
               end
            endcase

            // Disconnect notice anywhere before the first zero byte.
            if (!disc_ff) begin
               if (c == alrc_pkg::pat_byte(alrc_pkg::PAT_DISC, 17, int'(dcnt_ff))) begin
                  if (dcnt_ff == 5'd16) begin
                     disc_in = 1'b1;
                  end else begin
                     dcnt_in = dcnt_ff + 5'd1;
                  end
               end else begin
                  dcnt_in = (c == alrc_pkg::CH_PLUS) ? 5'd1 : 5'd0;
               end
            end
         end

         // Whole-line words with CR and LF trimmed at both ends.
         if (alrc_pkg::is_crlf(c)) begin
            if (wstart_ff) begin
               wgap_in = 1'b1;
            end
         end else begin
            wstart_in = 1'b1;
            if (!wgap_ff && okcnt_ff < 2'd2 &&
                c == alrc_pkg::pat_byte(alrc_pkg::PAT_OK, 2, int'(okcnt_ff))) begin
               okcnt_in = okcnt_ff + 2'd1;
            end else begin
               okbad_in = 1'b1;
            end
            if (!wgap_ff && errcnt_ff < 3'd5 &&
                c == alrc_pkg::pat_byte(alrc_pkg::PAT_ERR, 5, int'(errcnt_ff))) begin
               errcnt_in = errcnt_ff + 3'd1;
            end else begin
               errbad_in = 1'b1;
            end
            if (!wgap_ff && failcnt_ff < 3'd4 &&
                c == alrc_pkg::pat_byte(alrc_pkg::PAT_FAIL, 4, int'(failcnt_ff))) begin
               failcnt_in = failcnt_ff + 3'd1;
            end else begin
               failbad_in = 1'b1;
            end
         end

         // Last run of bytes before trailing CR and LF.
         if (alrc_pkg::is_crlf(c)) begin
            bbrk_in = 1'b1;
         end else begin
            bwin_in = {bwin_ff[63:0], c};
            bbrk_in = 1'b0;
            if (bbrk_ff) begin
               brun_in = 4'd1;
            end else if (brun_ff < 4'd9) begin
               brun_in = brun_ff + 4'd1;
            end
         end
      end

      if (cmd.restart) begin
         fill_in    = '0;
         zseen_in   = 1'b0;
         phase_in   = alrc_pkg::PH_SEEK;
         mcnt_in    = '0;
         dcnt_in    = '0;
         disc_in    = 1'b0;
         wstart_in  = 1'b0;
         wgap_in    = 1'b0;
         okcnt_in   = '0;
         errcnt_in  = '0;
         failcnt_in = '0;
         okbad_in   = 1'b0;
         errbad_in  = 1'b0;
         failbad_in = 1'b0;
         brun_in    = '0;
         bbrk_in    = 1'b0;
      end
   end

   // Result register loading.
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.chunk_load) begin
         out_in           = '0;
         out_in.line_kind = alrc_pkg::KIND_CHUNK;
         out_in.line_len  = fill_ff;
         out_in.last      = (c != alrc_pkg::CH_LF);
         out_valid_in     = 1'b1;
      end else if (cmd.line_load) begin
         out_in           = '0;
         out_in.line_kind = kind;
         out_in.line_len  = fill_ff;
         out_in.last      = 1'b1;
         if (mqtt_hit) begin
            out_in.topic_start = t1_ff + 10'd1;
            out_in.topic_size  = (topic_raw > 10'(alrc_pkg::TOPIC_MAX - 1)) ?
                                 6'(alrc_pkg::TOPIC_MAX - 1) : topic_raw[5:0];
            out_in.body_start  = c2_ff + 10'd1;
            out_in.payload_len = (mag_ff > 17'(alrc_pkg::PAYLOAD_MAX - 1)) ?
                                 8'(alrc_pkg::PAYLOAD_MAX - 1) : mag_ff[7:0];
         end
         out_valid_in = 1'b1;
      end else if (cmd.read_load) begin
         out_in           = '0;
         out_in.line_kind = alrc_pkg::KIND_READ;
         out_in.read_data = rd_data;
         out_in.last      = 1'b1;
         out_valid_in     = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         zseen_ff     <= 1'b0;
         phase_ff     <= alrc_pkg::PH_SEEK;
         mcnt_ff      <= '0;
         parse_ff     <= alrc_pkg::PARSE_DONE;
         dcnt_ff      <= '0;
         disc_ff      <= 1'b0;
         wstart_ff    <= 1'b0;
         wgap_ff      <= 1'b0;
         okcnt_ff     <= '0;
         errcnt_ff    <= '0;
         failcnt_ff   <= '0;
         okbad_ff     <= 1'b0;
         errbad_ff    <= 1'b0;
         failbad_ff   <= 1'b0;
         brun_ff      <= '0;
         bbrk_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         zseen_ff     <= zseen_in;
         phase_ff     <= phase_in;
         mcnt_ff      <= mcnt_in;
         parse_ff     <= parse_in;
         dcnt_ff      <= dcnt_in;
         disc_ff      <= disc_in;
         wstart_ff    <= wstart_in;
         wgap_ff      <= wgap_in;
         okcnt_ff     <= okcnt_in;
         errcnt_ff    <= errcnt_in;
         failcnt_ff   <= failcnt_in;
         okbad_ff     <= okbad_in;
         errbad_ff    <= errbad_in;
         failbad_ff   <= failbad_in;
         brun_ff      <= brun_in;
         bbrk_ff      <= bbrk_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      c2_ff   <= c2_in;
      trim_ff <= trim_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      bwin_ff <= bwin_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

/* design/at_response_line_classifier_unit.sv */
// ---------------------------------------------------------------------------
// Modem response line classifier, top level
// An accepted byte passes through the decode and step states; a newline adds
// the line state; a byte that overflows the line store adds the chunk state.
// A read goes through the decode, read and read-out states.
// One request is handled at a time; results wait in an output register.
// Reset clears fill and tracker counts, not payload registers or the store.
// ---------------------------------------------------------------------------
`include "at_response_line_classifier_unit_assert.svh"

module at_response_line_classifier_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  alrc_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output alrc_pkg::rsp_item_type rsp_data
);

   alrc_pkg::alrc_cmd_type    cmd;
   alrc_pkg::alrc_status_type status;
   alrc_pkg::ctrl_state_type  state;

   logic                        wr_en;
   logic [alrc_pkg::ADDR_W-1:0] wr_addr;
   logic [7:0]                  wr_data;
   logic [alrc_pkg::ADDR_W-1:0] rd_addr;
   logic [7:0]                  rd_data;

   // Controller.
   alrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   // Datapath.
   alrc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // Line store.
   alrc_ram #(
      .WIDTH (8),
      .DEPTH (alrc_pkg::LINE_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A new request is never taken while one is in progress.
   `ALRC_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
   // The store is only written in the step state.
   `ALRC_ASSERT_SAME(a_write_in_step, wr_en, state == alrc_pkg::ST_STEP)
   // An overflow chunk always reports a line length of LINE_MAX - 1.
   `ALRC_ASSERT_SAME(a_chunk_len, rsp_valid && rsp_data.line_kind == alrc_pkg::KIND_CHUNK,
                     rsp_data.line_len == 10'(alrc_pkg::LINE_MAX - 1))

endmodule
